// ----- rtl/fifo_with_deferred_release_assert.svh -----
// Assertion macros for the deferred-release queue.
`ifndef FIFO_WITH_DEFERRED_RELEASE_ASSERT_SVH
`define FIFO_WITH_DEFERRED_RELEASE_ASSERT_SVH

// A condition that holds at every clock edge out of reset.
`define FDR_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("deferred-release queue assertion failed");

// A consequence that holds in the same cycle as its antecedent.
`define FDR_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deferred-release queue assertion failed");

// A consequence that holds in the cycle after its antecedent.
`define FDR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deferred-release queue assertion failed");

`endif

// ----- rtl/fdr_pkg.sv -----
// Package with the constants, types and pointer helpers of the deferred-release queue.
`timescale 1ns / 1ps

package fdr_pkg;

	localparam int DEPTH            = 16;
	localparam int DATA_W           = 32;
	localparam int RELEASE_PER_PUSH = 2;

	localparam int PTR_MOD = 2 * DEPTH;
	localparam int PTR_W   = $clog2(PTR_MOD);
	localparam int SLOT_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(RELEASE_PER_PUSH + 1);

	localparam logic [1:0] OP_PUSH   = 2'd0;
	localparam logic [1:0] OP_POP    = 2'd1;
	localparam logic [1:0] OP_COMMIT = 2'd2;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [SLOT_W-1:0] slot_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] push_data;
		logic [3:0]  commit_slot;
	} req_t;

	typedef struct packed {
		logic        push_accepted;
		logic [1:0]  freed_count;
		logic        pop_valid;
		logic [3:0]  pop_slot;
		logic [31:0] pop_data;
	} rsp_t;

	typedef struct packed {
		logic  en;
		slot_t addr;
		logic  val;
	} mark_wr_t;

	typedef struct packed {
		logic              en;
		slot_t             addr;
		logic [DATA_W-1:0] data;
	} payload_wr_t;

	function automatic ptr_t ptr_next(input ptr_t p);
		ptr_t r;
		if (p == PTR_W'(PTR_MOD - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	function automatic slot_t ptr_slot(input ptr_t p);
		ptr_t r;
		if (p >= PTR_W'(DEPTH)) begin
			r = p - PTR_W'(DEPTH);
		end else begin
			r = p;
		end
		return SLOT_W'(r);
	endfunction

	function automatic ptr_t ptr_dist(input ptr_t a, input ptr_t b);
		logic [PTR_W:0] s;
		s = {1'b0, a} + (PTR_W + 1)'(PTR_MOD) - {1'b0, b};
		if (a >= b) begin
			s = {1'b0, a} - {1'b0, b};
		end
		return PTR_W'(s);
	endfunction

endpackage

// ----- rtl/fdr_mark_store.sv -----
// Consumed-mark memory with per-entry valid bits that reset clears.
`timescale 1ns / 1ps

module fdr_mark_store (
	input  logic             clk,
	input  logic             arst_n,
	input  fdr_pkg::mark_wr_t wr,
	input  fdr_pkg::slot_t   raddr,
	output logic             rdata
);

	logic                     mem [fdr_pkg::DEPTH];
	logic [fdr_pkg::DEPTH-1:0] valid_q;
	logic                     mem_rd_q;
	logic                     valid_rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.val;
		end
		mem_rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			valid_rd_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			valid_rd_q <= valid_q[raddr];
		end
	end

	assign rdata = valid_rd_q & mem_rd_q;

endmodule

// ----- rtl/fdr_payload_store.sv -----
// Payload memory with one write port and one registered read port.
`timescale 1ns / 1ps

module fdr_payload_store (
	input  logic                       clk,
	input  fdr_pkg::payload_wr_t       wr,
	input  fdr_pkg::slot_t             raddr,
	output logic [fdr_pkg::DATA_W-1:0] rdata
);

	logic [fdr_pkg::DATA_W-1:0] mem [fdr_pkg::DEPTH];
	logic [fdr_pkg::DATA_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_q <= mem[raddr];
	end

	assign rdata = rd_q;

endmodule

// ----- rtl/fifo_with_deferred_release.sv -----
// Top level of the deferred-release queue: pointers, sequencer and result register.
`timescale 1ns / 1ps
`include "fifo_with_deferred_release_assert.svh"

// A transaction is taken at a rising edge with start high and busy low; req carries
// the operation (push, pop or commit), the push payload and the slot to commit.
// Exactly one result follows each transaction, shown on rsp while done is high
// for a single cycle. The receiver cannot stall, so the result must be taken then.
// A commit, or an unused operation code, gives its result in the cycle after the
// transaction. A pop reads the payload memory in S_POP, which registers its result.
// A push checks one consumed mark per cycle from the release pointer in S_REL, up
// to two, then appends in S_APPEND, which registers its result; the mark memory's
// single read port sets that pace.
// busy is high from the accepting edge of a push or pop until the result is on
// rsp; other operations leave it low. A new transaction may be taken in the
// cycle that shows the result. Reset clears the pointers and the mark valid bits
// at once, so the queue is empty and every slot unconsumed; no clearing pass is
// needed. The payload memory is not cleared; a pop only returns written data.

module fifo_with_deferred_release (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  fdr_pkg::req_t req,
	output logic          done,
	output fdr_pkg::rsp_t rsp
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_REL    = 4'b0010,
		S_APPEND = 4'b0100,
		S_POP    = 4'b1000
	} state_t;

	state_t                     state_q;
	fdr_pkg::ptr_t              wr_q;
	fdr_pkg::ptr_t              rd_q;
	fdr_pkg::ptr_t              rel_q;
	logic [fdr_pkg::CNT_W-1:0]  freed_q;
	logic                       done_q;
	fdr_pkg::rsp_t              rsp_q;
	fdr_pkg::rsp_t              rsp_d;
	logic [fdr_pkg::DATA_W-1:0] data_q;

	logic                       accept;
	fdr_pkg::ptr_t              rel_next;
	fdr_pkg::slot_t             mark_raddr;
	logic                       mark_rdata;
	logic                       can_free;
	logic                       full;
	logic                       not_empty;
	logic                       commit_ok;
	fdr_pkg::ptr_t              cslot_w;
	fdr_pkg::ptr_t              base_w;
	fdr_pkg::ptr_t              off;
	fdr_pkg::mark_wr_t          mark_wr;
	fdr_pkg::payload_wr_t       payload_wr;
	logic [fdr_pkg::DATA_W-1:0] payload_rdata;

	assign accept    = start && (state_q == S_IDLE);
	assign rel_next  = fdr_pkg::ptr_next(rel_q);
	assign can_free  = (rel_q != rd_q) && mark_rdata;
	assign full      = fdr_pkg::ptr_dist(wr_q, rel_q) >= fdr_pkg::PTR_W'(fdr_pkg::DEPTH);
	assign not_empty = rd_q != wr_q;

	always_comb begin
		cslot_w = fdr_pkg::PTR_W'(req.commit_slot);
		base_w  = fdr_pkg::PTR_W'(fdr_pkg::ptr_slot(rel_q));
		if (cslot_w >= base_w) begin
			off = cslot_w - base_w;
		end else begin
			off = cslot_w + fdr_pkg::PTR_W'(fdr_pkg::DEPTH) - base_w;
		end
		commit_ok = (int'(req.commit_slot) < fdr_pkg::DEPTH)
			&& (off < fdr_pkg::ptr_dist(rd_q, rel_q));
	end

	always_comb begin
		mark_raddr = fdr_pkg::ptr_slot(rel_q);
		if (state_q == S_REL) begin
			mark_raddr = fdr_pkg::ptr_slot(rel_next);
		end
	end

	always_comb begin
		mark_wr = '0;
		if (accept && (req.operation == fdr_pkg::OP_COMMIT) && commit_ok) begin
			mark_wr.en   = 1'b1;
			mark_wr.addr = fdr_pkg::SLOT_W'(req.commit_slot);
			mark_wr.val  = 1'b1;
		end else if ((state_q == S_REL) && can_free) begin
			mark_wr.en   = 1'b1;
			mark_wr.addr = fdr_pkg::ptr_slot(rel_q);
			mark_wr.val  = 1'b0;
		end
	end

	always_comb begin
		payload_wr.en   = (state_q == S_APPEND) && !full;
		payload_wr.addr = fdr_pkg::ptr_slot(wr_q);
		payload_wr.data = data_q;
	end

	fdr_mark_store u_marks (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (mark_wr),
		.raddr  (mark_raddr),
		.rdata  (mark_rdata)
	);

	fdr_payload_store u_payload (
		.clk   (clk),
		.wr    (payload_wr),
		.raddr (fdr_pkg::ptr_slot(rd_q)),
		.rdata (payload_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wr_q    <= '0;
			rd_q    <= '0;
			rel_q   <= '0;
			freed_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (req.operation)
							fdr_pkg::OP_PUSH: begin
								freed_q <= '0;
								state_q <= S_REL;
							end
							fdr_pkg::OP_POP: begin
								state_q <= S_POP;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_REL: begin
					if (can_free) begin
						rel_q   <= rel_next;
						freed_q <= freed_q + fdr_pkg::CNT_W'(1);
						if (freed_q == fdr_pkg::CNT_W'(fdr_pkg::RELEASE_PER_PUSH - 1)) begin
							state_q <= S_APPEND;
						end
					end else begin
						state_q <= S_APPEND;
					end
				end
				S_APPEND: begin
					if (!full) begin
						wr_q <= fdr_pkg::ptr_next(wr_q);
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_POP: begin
					if (not_empty) begin
						rd_q <= fdr_pkg::ptr_next(rd_q);
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		rsp_d = rsp_q;
		if (accept) begin
			rsp_d = '0;
		end
		if (state_q == S_APPEND) begin
			rsp_d               = '0;
			rsp_d.push_accepted = !full;
			rsp_d.freed_count   = 2'(freed_q);
		end
		if (state_q == S_POP) begin
			rsp_d = '0;
			if (not_empty) begin
				rsp_d.pop_valid = 1'b1;
				rsp_d.pop_slot  = 4'(fdr_pkg::ptr_slot(rd_q));
				rsp_d.pop_data  = 32'(payload_rdata);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= req.push_data;
		end
		rsp_q <= rsp_d;
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

	`FDR_ASSERT_IMPL(a_no_result_while_busy, busy, !done)
	`FDR_ASSERT_NEXT(a_accept_answered, start && !busy, busy || done)
	`FDR_ASSERT_ALWAYS(a_pointer_order,
		(fdr_pkg::ptr_dist(rd_q, rel_q) <= fdr_pkg::ptr_dist(wr_q, rel_q))
		&& (fdr_pkg::ptr_dist(wr_q, rel_q) <= fdr_pkg::PTR_W'(fdr_pkg::DEPTH)))
	`FDR_ASSERT_IMPL(a_push_result_from_append, done && rsp.push_accepted,
		$past(state_q == S_APPEND))

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the deferred-release queue: directed and random transactions against a ring predictor.

module testbench;
	import fdr_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES = 8;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t req;
	rsp_t rsp;

	logic [DATA_W-1:0] ring_data [DEPTH];
	logic ring_consumed [DEPTH];
	ptr_t wr_ptr;
	ptr_t rd_ptr;
	ptr_t rel_ptr;

	rsp_t awaited_results [$];
	int err_count;
	int idle_cycles;
	bit gaps_on;

	fifo_with_deferred_release u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	always #10 clk = ~clk;

	function automatic ptr_t ptr_step(input ptr_t p);
		return (int'(p) == PTR_MOD - 1) ? ptr_t'(0) : ptr_t'(int'(p) + 1);
	endfunction

	function automatic int ptr_gap(input ptr_t a, input ptr_t b);
		return (int'(a) + PTR_MOD - int'(b)) % PTR_MOD;
	endfunction

	function automatic slot_t slot_of(input ptr_t p);
		return slot_t'(int'(p) % DEPTH);
	endfunction

	function automatic req_t make_req(input logic [1:0] op, input logic [31:0] data,
			input logic [3:0] slot);
		req_t r;
		r.operation = op;
		r.push_data = data;
		r.commit_slot = slot;
		return r;
	endfunction

	// Applies one transaction to the ring and returns the result it should give.
	function automatic rsp_t ring_apply(input req_t t);
		rsp_t r;
		slot_t s;
		int k;
		int offset;
		bit stop;
		r = '0;
		stop = 1'b0;
		case (t.operation)
			OP_PUSH: begin
				for (k = 0; k < RELEASE_PER_PUSH; k++) begin
					s = slot_of(rel_ptr);
					if (rel_ptr == rd_ptr || !ring_consumed[s]) begin
						stop = 1'b1;
					end
					if (!stop) begin
						ring_consumed[s] = 1'b0;
						rel_ptr = ptr_step(rel_ptr);
						r.freed_count = r.freed_count + 2'd1;
					end
				end
				if (ptr_gap(wr_ptr, rel_ptr) < DEPTH) begin
					s = slot_of(wr_ptr);
					ring_data[s] = t.push_data;
					ring_consumed[s] = 1'b0;
					wr_ptr = ptr_step(wr_ptr);
					r.push_accepted = 1'b1;
				end
			end
			OP_POP: begin
				if (rd_ptr != wr_ptr) begin
					s = slot_of(rd_ptr);
					r.pop_valid = 1'b1;
					r.pop_slot = s;
					r.pop_data = ring_data[s];
					rd_ptr = ptr_step(rd_ptr);
				end
			end
			OP_COMMIT: begin
				offset = (int'(t.commit_slot) + DEPTH - int'(slot_of(rel_ptr))) % DEPTH;
				if (offset < ptr_gap(rd_ptr, rel_ptr)) begin
					ring_consumed[t.commit_slot] = 1'b1;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50) begin
			return 0;
		end else if (roll < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch: %s got %0h expected %0h", what, got, want);
		err_count++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch(what, got, want);
		end
	endtask

	task automatic send_item(input req_t item);
		int gap;
		gap = gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= item;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		awaited_results.push_back(ring_apply(item));
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
	endtask

	task automatic commit_oldest(input int count);
		int i;
		for (i = 0; i < count; i++) begin
			send_item(make_req(OP_COMMIT, 32'h0,
				4'((int'(slot_of(rel_ptr)) + i) % DEPTH)));
		end
	endtask

	task automatic test_empty_queue();
		send_item(make_req(OP_POP, 32'h0, 4'd0));
		send_item(make_req(OP_NONE, 32'hFFFF_FFFF, 4'hF));
		send_item(make_req(OP_COMMIT, 32'h0, 4'd0));
		send_item(make_req(OP_COMMIT, 32'h0, 4'hF));
		send_item(make_req(OP_PUSH, 32'h0000_0000, 4'hF));
	endtask

	task automatic test_release_order();
		int i;
		send_item(make_req(OP_PUSH, 32'hFFFF_FFFF, 4'd0));
		send_item(make_req(OP_PUSH, 32'h5A5A_A5A5, 4'd0));
		for (i = 0; i < 3; i++) begin
			send_item(make_req(OP_POP, 32'h0, 4'd0));
		end
		// Slot 1 is marked but slot 0 is not, so the next push frees nothing.
		send_item(make_req(OP_COMMIT, 32'h0, 4'd1));
		send_item(make_req(OP_PUSH, 32'hA5A5_5A5A, 4'd0));
		send_item(make_req(OP_COMMIT, 32'h0, 4'd0));
		send_item(make_req(OP_COMMIT, 32'h0, 4'd0));
		send_item(make_req(OP_PUSH, 32'h8000_0001, 4'd0));
		send_item(make_req(OP_COMMIT, 32'h0, 4'd2));
		send_item(make_req(OP_PUSH, 32'h7FFF_FFFE, 4'd0));
		send_item(make_req(OP_COMMIT, 32'h0, 4'd7));
		for (i = 0; i < 4; i++) begin
			send_item(make_req(OP_POP, 32'h0, 4'd0));
		end
	endtask

	task automatic test_full_ring();
		while (ptr_gap(wr_ptr, rel_ptr) < DEPTH) begin
			send_item(make_req(OP_PUSH, $urandom(), 4'($urandom())));
		end
		send_item(make_req(OP_PUSH, 32'hDEAD_BEEF, 4'd0));
		repeat (4) send_item(make_req(OP_POP, 32'h0, 4'd0));
		send_item(make_req(OP_PUSH, 32'hCAFE_F00D, 4'd0));
		commit_oldest(4);
		send_item(make_req(OP_PUSH, $urandom(), 4'd0));
		send_item(make_req(OP_PUSH, $urandom(), 4'd0));
		send_item(make_req(OP_PUSH, $urandom(), 4'd0));
		wait_for_results();
		while (rd_ptr != wr_ptr) begin
			send_item(make_req(OP_POP, 32'h0, 4'd0));
		end
		send_item(make_req(OP_POP, 32'h0, 4'd0));
		commit_oldest(ptr_gap(rd_ptr, rel_ptr));
	endtask

	task automatic test_random(input int count);
		int i;
		int roll;
		int span;
		int push_w;
		int pop_w;
		logic [3:0] slot;
		for (i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				case ($urandom_range(0, 3))
					0: begin push_w = 60; pop_w = 20; gaps_on = 1'b1; end
					1: begin push_w = 20; pop_w = 40; gaps_on = 1'b1; end
					2: begin push_w = 34; pop_w = 33; gaps_on = 1'b1; end
					default: begin push_w = 34; pop_w = 33; gaps_on = 1'b0; end
				endcase
			end
			roll = $urandom_range(0, 99);
			span = ptr_gap(rd_ptr, rel_ptr);
			if (roll < 3) begin
				send_item(make_req(OP_NONE, $urandom(), 4'($urandom())));
			end else if (roll < 6) begin
				send_item(make_req(OP_COMMIT, $urandom(), 4'($urandom())));
			end else if (roll < 6 + push_w) begin
				send_item(make_req(OP_PUSH, $urandom(), 4'($urandom())));
			end else if (roll < 6 + push_w + pop_w || span == 0) begin
				send_item(make_req(OP_POP, $urandom(), 4'($urandom())));
			end else begin
				slot = 4'((int'(slot_of(rel_ptr)) + $urandom_range(0, span - 1)) % DEPTH);
				send_item(make_req(OP_COMMIT, $urandom(), slot));
			end
		end
		gaps_on = 1'b1;
	endtask

	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("result with no transaction waiting", rsp.pop_data, 32'h0);
			end else begin
				want = awaited_results.pop_front();
				check_field("push_accepted", rsp.push_accepted, want.push_accepted);
				check_field("freed_count", rsp.freed_count, want.freed_count);
				check_field("pop_valid", rsp.pop_valid, want.pop_valid);
				check_field("pop_slot", rsp.pop_slot, want.pop_slot);
				check_field("pop_data", rsp.pop_data, want.pop_data);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int i;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		err_count = 0;
		idle_cycles = 0;
		gaps_on = 1'b1;
		for (i = 0; i < DEPTH; i++) begin
			ring_data[i] = '0;
			ring_consumed[i] = 1'b0;
		end
		wr_ptr = '0;
		rd_ptr = '0;
		rel_ptr = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_queue();
		test_release_order();
		test_full_ring();
		test_random(360);
		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
